// ===== rtl/core/htle_pkg.sv =====
// ----------------------------------------------------------------------------
// htle_pkg
// Types, result codes, tag patterns and character helpers for the html text
// and link extractor.
// ----------------------------------------------------------------------------
package htle_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_document;
  } doc_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last_of_run;
  } res_item_t;

  localparam logic [1:0] KIND_TEXT     = 2'd0;
  localparam logic [1:0] KIND_URL_BYTE = 2'd1;
  localparam logic [1:0] KIND_URL_END  = 2'd2;
  localparam logic [1:0] KIND_DOC_END  = 2'd3;

  // patterns are upper case, first byte at index 0, zero padded
  typedef logic [0:7][7:0] pat_t;

  localparam pat_t PAT_SCRIPT   = {"<SCRIPT", 8'h00};
  localparam pat_t PAT_COMMENT  = {"<!--", 32'h0};
  localparam pat_t PAT_ANCHOR   = {"<A ", 40'h0};
  localparam pat_t PAT_FRAME    = {"<FRAME ", 8'h00};
  localparam pat_t PAT_STYLE    = {"<STYLE", 16'h0};
  localparam pat_t PAT_HREF     = {"HREF=\"", 16'h0};
  localparam pat_t PAT_SRC      = {"SRC=\"", 24'h0};
  localparam pat_t PAT_END_SCR  = "/SCRIPT>";
  localparam pat_t PAT_END_COM  = {"-->", 40'h0};
  localparam pat_t PAT_END_STY  = {"/STYLE>", 8'h00};

  localparam logic [3:0] LEN_SCRIPT  = 4'd7;
  localparam logic [3:0] LEN_COMMENT = 4'd4;
  localparam logic [3:0] LEN_ANCHOR  = 4'd3;
  localparam logic [3:0] LEN_FRAME   = 4'd7;
  localparam logic [3:0] LEN_STYLE   = 4'd6;
  localparam logic [3:0] LEN_HREF    = 4'd6;
  localparam logic [3:0] LEN_SRC     = 4'd5;
  localparam logic [3:0] LEN_END_SCR = 4'd8;
  localparam logic [3:0] LEN_END_COM = 4'd3;
  localparam logic [3:0] LEN_END_STY = 4'd7;

  function automatic logic [7:0] up_ascii(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] down_ascii(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h0a, 8'h0d, 8'h09, 8'h20};
  endfunction

  function automatic logic is_dropped(input logic [7:0] c);
    return c inside {".", ",", ";", ":", "!", "?", "(", ")", "{", "}", "[", "]",
                     "-", "^", "\"", "|", "#", "$", "'", "%"};
  endfunction

  // byte compare of the upper-cased head against the first len pattern bytes
  function automatic logic pat_hit(input pat_t head_up, input pat_t pat,
                                   input logic [3:0] len);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(len) && head_up[i] != pat[i]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

// ===== rtl/core/html_text_and_link_extractor.sv =====
// ----------------------------------------------------------------------------
// html_text_and_link_extractor
// Strips an html byte stream to lower-case text and pulls out quoted link
// targets of anchor and frame tags.
// ----------------------------------------------------------------------------
// One document byte is taken per cycle while doc_stall is low. Bytes fill a
// LOOKAHEAD-byte window; each byte that fills it runs one parse step on the
// window head, which consumes one or more bytes, and gives at most one result,
// registered and shown the cycle after the byte is taken. A byte flagged
// end_of_document stops intake while the window drains: one parse step per
// cycle while the result register is free, for each step the remaining bytes
// need, then the document end result, after which the next document can start;
// res_stall holding the result register delays this.
module html_text_and_link_extractor
  import htle_pkg::*;
#(
  parameter int LOOKAHEAD = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      doc_valid,
  output logic      doc_stall,
  input  doc_item_t doc_item,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res_item
);

  localparam int CW = $clog2(LOOKAHEAD + 1);
  localparam int IW = $clog2(LOOKAHEAD);

  localparam logic [3:0] M_TEXT    = 4'd0;
  localparam logic [3:0] M_TAG     = 4'd1;
  localparam logic [3:0] M_SCRIPT  = 4'd2;
  localparam logic [3:0] M_ANCHOR  = 4'd3;
  localparam logic [3:0] M_HREF    = 4'd4;
  localparam logic [3:0] M_COMMENT = 4'd5;
  localparam logic [3:0] M_FRAME   = 4'd6;
  localparam logic [3:0] M_SRC     = 4'd7;
  localparam logic [3:0] M_STYLE   = 4'd8;
  localparam logic [3:0] M_ENTITY  = 4'd9;

  logic [7:0]    window [LOOKAHEAD];
  logic [7:0]    window_next [LOOKAHEAD];
  logic [CW-1:0] fill, fill_next;
  logic [3:0]    mode, mode_next;
  logic          prev_space, prev_space_next;
  logic          prev_text, prev_text_next;
  logic          drain, drain_next;
  logic          res_valid_next;
  res_item_t     res_item_next;

  logic          doc_accept, out_free, full_now, drain_step, drain_done, load;
  logic [7:0]    win_ins [LOOKAHEAD];
  logic [7:0]    step_win [LOOKAHEAD];
  logic [7:0]    win_shift [LOOKAHEAD];
  logic [CW-1:0] step_cnt;
  pat_t          head_up;
  logic [7:0]    head0;

  logic hit_script, hit_comment, hit_anchor, hit_frame, hit_style;
  logic hit_href, hit_src, hit_end_scr, hit_end_com, hit_end_sty;

  // parse step results
  logic [3:0] k;
  logic [3:0] s_mode;
  logic       s_space, s_text, s_emit;
  logic [1:0] s_kind;
  logic [7:0] s_value;

  assign out_free   = !res_valid || !res_stall;
  assign doc_stall  = drain || (res_valid && res_stall);
  assign doc_accept = doc_valid && !doc_stall;
  assign full_now   = (fill == CW'(LOOKAHEAD - 1));
  assign drain_step = drain && out_free && (fill != '0);
  assign drain_done = drain && out_free && (fill == '0);

  always_comb begin
    for (int i = 0; i < LOOKAHEAD; i++) begin
      win_ins[i] = (CW'(i) == fill) ? doc_item.data_byte : window[i];
      step_win[i] = drain ? window[i] : win_ins[i];
    end
    step_cnt = drain ? fill : CW'(LOOKAHEAD);
    for (int i = 0; i < 8; i++) begin
      head_up[i] = up_ascii(step_win[i]);
    end
    head0 = step_win[0];
  end

  assign hit_script  = pat_hit(head_up, PAT_SCRIPT, LEN_SCRIPT)
                       && (CW'(LEN_SCRIPT) <= step_cnt);
  assign hit_comment = pat_hit(head_up, PAT_COMMENT, LEN_COMMENT)
                       && (CW'(LEN_COMMENT) <= step_cnt);
  assign hit_anchor  = pat_hit(head_up, PAT_ANCHOR, LEN_ANCHOR)
                       && (CW'(LEN_ANCHOR) <= step_cnt);
  assign hit_frame   = pat_hit(head_up, PAT_FRAME, LEN_FRAME)
                       && (CW'(LEN_FRAME) <= step_cnt);
  assign hit_style   = pat_hit(head_up, PAT_STYLE, LEN_STYLE)
                       && (CW'(LEN_STYLE) <= step_cnt);
  assign hit_href    = pat_hit(head_up, PAT_HREF, LEN_HREF)
                       && (CW'(LEN_HREF) <= step_cnt);
  assign hit_src     = pat_hit(head_up, PAT_SRC, LEN_SRC)
                       && (CW'(LEN_SRC) <= step_cnt);
  assign hit_end_scr = pat_hit(head_up, PAT_END_SCR, LEN_END_SCR)
                       && (CW'(LEN_END_SCR) <= step_cnt);
  assign hit_end_com = pat_hit(head_up, PAT_END_COM, LEN_END_COM)
                       && (CW'(LEN_END_COM) <= step_cnt);
  assign hit_end_sty = pat_hit(head_up, PAT_END_STY, LEN_END_STY)
                       && (CW'(LEN_END_STY) <= step_cnt);

  // one parse step on the window head
  always_comb begin
    k       = 4'd1;
    s_mode  = mode;
    s_space = prev_space;
    s_text  = prev_text;
    s_emit  = 1'b0;
    s_kind  = KIND_TEXT;
    s_value = 8'h00;
    case (mode)
      M_TAG: begin
        if (head0 == ">") s_mode = M_TEXT;
      end
      M_ENTITY: begin
        if (head0 == ";") s_mode = M_TEXT;
      end
      M_SCRIPT: begin
        if (hit_end_scr) begin
          s_mode = M_TEXT;
          k      = LEN_END_SCR;
        end
      end
      M_COMMENT: begin
        if (hit_end_com) begin
          s_mode = M_TEXT;
          k      = LEN_END_COM;
        end
      end
      M_STYLE: begin
        if (hit_end_sty) begin
          s_mode = M_TEXT;
          k      = LEN_END_STY;
        end
      end
      M_ANCHOR: begin
        if (hit_href) begin
          s_mode = M_HREF;
          k      = LEN_HREF;
        end else if (head0 == ">") begin
          s_mode = M_TEXT;
        end
      end
      M_FRAME: begin
        if (hit_src) begin
          s_mode = M_SRC;
          k      = LEN_SRC;
        end else if (head0 == ">") begin
          s_mode = M_TEXT;
        end
      end
      M_HREF, M_SRC: begin
        s_emit = 1'b1;
        if (head0 == "\"") begin
          s_mode = (mode == M_HREF) ? M_ANCHOR : M_FRAME;
          s_kind = KIND_URL_END;
        end else begin
          s_kind  = KIND_URL_BYTE;
          s_value = head0;
        end
      end
      default: begin
        if (head0 == "<") begin
          // any tag: space between text and tag
          if (hit_script) begin
            s_mode = M_SCRIPT;
            k      = LEN_SCRIPT;
          end else if (hit_comment) begin
            s_mode = M_COMMENT;
            k      = LEN_COMMENT;
          end else if (hit_anchor) begin
            s_mode = M_ANCHOR;
            k      = LEN_ANCHOR;
          end else if (hit_frame) begin
            s_mode = M_FRAME;
            k      = LEN_FRAME;
          end else if (hit_style) begin
            s_mode = M_STYLE;
            k      = LEN_STYLE;
          end else begin
            s_mode = M_TAG;
          end
          if (prev_text) begin
            s_emit  = 1'b1;
            s_value = " ";
            s_text  = 1'b0;
          end
        end else if (head0 == "&") begin
          s_mode = M_ENTITY;
          s_text = 1'b0;
        end else if (is_blank(head0)) begin
          if (!prev_space) begin
            s_emit  = 1'b1;
            s_value = " ";
          end
          s_space = 1'b1;
          s_text  = 1'b0;
        end else if (!is_dropped(head0)) begin
          s_emit  = 1'b1;
          s_value = down_ascii(head0);
          s_space = 1'b0;
          s_text  = 1'b1;
        end
      end
    endcase
  end

  // drop the consumed bytes from the window head
  always_comb begin
    int j;
    for (int i = 0; i < LOOKAHEAD; i++) begin
      j = i + int'(k);
      if (j < LOOKAHEAD) begin
        win_shift[i] = step_win[IW'(j)];
      end else begin
        win_shift[i] = step_win[i];
      end
    end
  end

  always_comb begin
    window_next     = window;
    fill_next       = fill;
    mode_next       = mode;
    prev_space_next = prev_space;
    prev_text_next  = prev_text;
    drain_next      = drain;
    load            = 1'b0;
    res_item_next   = res_item;

    if (doc_accept) begin
      if (doc_item.end_of_document) begin
        window_next = win_ins;
        fill_next   = fill + CW'(1);
        drain_next  = 1'b1;
      end else if (full_now) begin
        window_next     = win_shift;
        fill_next       = CW'(LOOKAHEAD) - CW'(k);
        mode_next       = s_mode;
        prev_space_next = s_space;
        prev_text_next  = s_text;
        load            = s_emit;
        res_item_next   = '{kind: s_kind, value: s_value, last_of_run: 1'b1};
      end else begin
        window_next = win_ins;
        fill_next   = fill + CW'(1);
      end
    end

    if (drain_step) begin
      window_next     = win_shift;
      fill_next       = fill - CW'(k);
      mode_next       = s_mode;
      prev_space_next = s_space;
      prev_text_next  = s_text;
      load            = s_emit;
      res_item_next   = '{kind: s_kind, value: s_value, last_of_run: 1'b0};
    end

    if (drain_done) begin
      fill_next       = '0;
      mode_next       = M_TEXT;
      prev_space_next = 1'b0;
      prev_text_next  = 1'b0;
      drain_next      = 1'b0;
      load            = 1'b1;
      res_item_next   = '{kind: KIND_DOC_END, value: 8'h00, last_of_run: 1'b1};
    end

    if (!load) begin
      res_item_next = res_item;
    end
    res_valid_next = load ? 1'b1 : (res_stall ? res_valid : 1'b0);
  end

  always_ff @(posedge clk) begin
    window   <= window_next;
    res_item <= res_item_next;
    if (rst) begin
      fill       <= '0;
      mode       <= M_TEXT;
      prev_space <= 1'b0;
      prev_text  <= 1'b0;
      drain      <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      fill       <= fill_next;
      mode       <= mode_next;
      prev_space <= prev_space_next;
      prev_text  <= prev_text_next;
      drain      <= drain_next;
      res_valid  <= res_valid_next;
    end
  end

  // outside a drain the window never holds a full row
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    !drain |-> fill < CW'(LOOKAHEAD))
    else $error("window fill out of range outside drain");

  // a document end result closes the run
  a_doc_end_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.kind == KIND_DOC_END |-> res_item.last_of_run)
    else $error("document end without last_of_run");

  // finishing a drain returns the parser to its reset state
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    drain_done |=> !drain && fill == '0 && mode == M_TEXT && !prev_space && !prev_text)
    else $error("parser not cleared after document end");

  // a loaded result is never overwritten while still stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> !load)
    else $error("result register overwritten while stalled");

endmodule
